// File: src/psde_pkg.sv
// psde_pkg: shared types and constants of the point set distance engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package psde_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned POINT_W  = 3 * COORD_W;
  localparam int unsigned D2_W     = 34;          // sum of three squared 17-bit differences
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned SQ_IN_W  = D2_W + 2 * FRAC_W;
  localparam int unsigned ROOT_W   = SQ_IN_W / 2;
  localparam int unsigned DIST_W   = 26;

  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_RMS       = 2'd0,
    MODE_CHAMFER   = 2'd1,
    MODE_HAUSDORFF = 2'd2,
    MODE_SPARE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2,
    STATUS_SPARE   = 2'd3
  } status_t;

endpackage

// File: src/psde_div.sv
// psde_div: restoring divider, one quotient bit per cycle
// depends on psde_pkg
`timescale 1ns / 1ps

module psde_div
  import psde_pkg::*;
#(
  parameter int unsigned DVD_W = 61,
  parameter int unsigned DVS_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             qbit;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    qbit    = (rem_sh >= {1'b0, dvs_r});
    rem_sub = qbit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        // quotient bits shift in where dividend bits leave
        dvd_r <= {dvd_r[DVD_W-2:0], qbit};
        rem_r <= rem_sub[DVS_W-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

// File: src/psde_isqrt.sv
// psde_isqrt: floored integer square root, one root bit per cycle
// depends on psde_pkg
`timescale 1ns / 1ps

module psde_isqrt
  import psde_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SQ_IN_W-1:0] radicand,
  output logic               done,
  output logic [ROOT_W-1:0]  root
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [SQ_IN_W-1:0] rad_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic               rbit;

  always_comb begin
    rem_sh = {rem_r, rad_r[SQ_IN_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    rbit   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[SQ_IN_W-3:0], 2'b00};
        rem_r  <= rbit ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], rbit};
        cnt_r  <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: src/point_set_distance_engine_top.sv
// point_set_distance_engine_top: point stores, scan sequencer and result register
// depends on psde_pkg, psde_div, psde_isqrt
//
//  channel | ports                    | content (low bit up)
//  in      | in_tvalid/tready/tdata   | tdata: coord_x, coord_y, coord_z; tuser: kind
//  out     | out_tvalid/tready/tdata  | tdata: dist_a_to_b, dist_b_to_a, combined; tuser: status
//  cfg     | cfg_we, cfg_wdata        | metric_mode
//
// loads and clears are handled in the idle state without leaving it. a compute scans each
// point of one set against every point of the other through one read port per store, with
// a square root per point in chamfer and hausdorff modes; each direction then ends with a
// divide (rms, chamfer) and a root (rms), and the result goes to the output register.
// input is taken only while the sequencer is idle; a finished result waits in the
// output register, loads keep flowing meanwhile. reset clears counts, flag and mode.
`timescale 1ns / 1ps

module point_set_distance_engine_top
  import psde_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // coord_x, coord_y, coord_z
  input  logic [1:0]    in_tuser,   // kind
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [79:0]   out_tdata,  // dist_a_to_b, dist_b_to_a, combined_distance, zero pad
  output logic [1:0]    out_tuser,  // status
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata   // metric_mode
);

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned ACC_W = D2_W + CW;
  localparam int unsigned DVD_W = ACC_W + 2 * FRAC_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_QRD, ST_QCAP, ST_SCAN, ST_DRAIN, ST_POINT, ST_PSQ,
    ST_FIN, ST_DIV, ST_RSQ, ST_DIR, ST_OUT
  } state_t;

  state_t            st_r;
  mode_t             cfg_mode_r;
  mode_t             mode_r;
  logic [CW-1:0]     count_a_r, count_b_r;
  logic              ovf_r;
  logic              dir_r;
  logic [AW-1:0]     i_r, j_r;
  logic [ACC_W-1:0]  acc_r;
  logic [DIST_W-1:0] dist_r, da_r, db_r;
  status_t           stat_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_da_r, out_db_r, out_comb_r;
  status_t           out_stat_r;
  logic              sq_start_r, dv_start_r;
  logic [SQ_IN_W-1:0] sq_in_r;
  logic [DVD_W-1:0]  dv_in_r;

  // point stores, one write and one read port each
  logic [POINT_W-1:0] mem_a [MAX_POINTS];
  logic [POINT_W-1:0] mem_b [MAX_POINTS];
  logic [POINT_W-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0]      addr_a, addr_b;
  logic               we_a, we_b;

  logic               in_fire;
  kind_t              in_kind;
  logic [CW-1:0]      nq, nt;
  logic               last_t, last_q;

  // scan pipeline
  logic [POINT_W-1:0] q_pt_r;
  logic               p1_v_r, p1_last_r, p2_v_r, p2_last_r;
  logic [31:0]        sqx_r, sqy_r, sqz_r;
  logic [D2_W-1:0]    best_r, d2_sum;
  logic [POINT_W-1:0] t_pt;
  logic signed [16:0] dx, dy, dz;
  logic signed [33:0] px, py, pz;

  logic               sq_done, dv_done;
  logic [ROOT_W-1:0]  root;
  logic [DVD_W-1:0]   quot;
  logic [DIST_W:0]    half_sum;

  assign in_tready = (st_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_kind   = kind_t'(in_tuser);

  assign we_a = in_fire && (in_kind == KIND_LOAD_A) && (count_a_r < CW'(MAX_POINTS));
  assign we_b = in_fire && (in_kind == KIND_LOAD_B) && (count_b_r < CW'(MAX_POINTS));

  assign nq     = dir_r ? count_b_r : count_a_r;
  assign nt     = dir_r ? count_a_r : count_b_r;
  assign last_t = (CW'(j_r) + CW'(1) == nt);
  assign last_q = (CW'(i_r) + CW'(1) == nq);

  // query side reads at i, target side at j; writes only happen while idle
  always_comb begin
    if (we_a)       addr_a = count_a_r[AW-1:0];
    else if (dir_r) addr_a = j_r;
    else            addr_a = i_r;
    if (we_b)       addr_b = count_b_r[AW-1:0];
    else if (dir_r) addr_b = i_r;
    else            addr_b = j_r;
  end

  always_ff @(posedge clk) begin
    if (we_a) mem_a[addr_a] <= in_tdata;
    rd_a_r <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[addr_b] <= in_tdata;
    rd_b_r <= mem_b[addr_b];
  end

  always_comb begin
    t_pt   = dir_r ? rd_a_r : rd_b_r;
    dx     = 17'(signed'(t_pt[15:0]))  - 17'(signed'(q_pt_r[15:0]));
    dy     = 17'(signed'(t_pt[31:16])) - 17'(signed'(q_pt_r[31:16]));
    dz     = 17'(signed'(t_pt[47:32])) - 17'(signed'(q_pt_r[47:32]));
    px     = dx * dx;
    py     = dy * dy;
    pz     = dz * dz;
    d2_sum = D2_W'(sqx_r) + D2_W'(sqy_r) + D2_W'(sqz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r    <= (st_r == ST_SCAN);
      p1_last_r <= last_t;
      p2_v_r    <= p1_v_r;
      p2_last_r <= p1_last_r;
      sqx_r     <= px[31:0];
      sqy_r     <= py[31:0];
      sqz_r     <= pz[31:0];
      if (st_r == ST_QCAP) begin
        q_pt_r <= dir_r ? rd_b_r : rd_a_r;
        best_r <= '1;
      end else if (p2_v_r && (d2_sum < best_r)) begin
        best_r <= d2_sum;
      end
    end
  end

  assign half_sum = ({1'b0, da_r} + {1'b0, db_r}) >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cfg_mode_r  <= MODE_RMS;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      sq_start_r  <= 1'b0;
      dv_start_r  <= 1'b0;
    end else begin
      sq_start_r <= 1'b0;
      dv_start_r <= 1'b0;
      if (cfg_we) cfg_mode_r <= mode_t'(cfg_wdata);
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_kind)
              KIND_LOAD_A: begin
                if (we_a) count_a_r <= count_a_r + CW'(1);
                else      ovf_r     <= 1'b1;
              end
              KIND_LOAD_B: begin
                if (we_b) count_b_r <= count_b_r + CW'(1);
                else      ovf_r     <= 1'b1;
              end
              KIND_CLEAR: begin
                count_a_r <= '0;
                count_b_r <= '0;
                ovf_r     <= 1'b0;
              end
              default: begin
                dir_r  <= 1'b0;
                i_r    <= '0;
                acc_r  <= '0;
                mode_r <= (cfg_mode_r == MODE_SPARE) ? MODE_RMS : cfg_mode_r;
                if (count_a_r == '0 || count_b_r == '0) begin
                  da_r   <= '0;
                  db_r   <= '0;
                  stat_r <= STATUS_EMPTY;
                  st_r   <= ST_OUT;
                end else begin
                  stat_r <= ovf_r ? STATUS_DROPPED : STATUS_OK;
                  st_r   <= ST_QRD;
                end
              end
            endcase
          end
        end
        ST_QRD: st_r <= ST_QCAP;
        ST_QCAP: begin
          j_r  <= '0;
          st_r <= ST_SCAN;
        end
        ST_SCAN: begin
          j_r <= j_r + AW'(1);
          if (last_t) st_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (p2_v_r && p2_last_r) st_r <= ST_POINT;
        end
        ST_POINT: begin
          if (mode_r == MODE_RMS) begin
            acc_r <= acc_r + ACC_W'(best_r);
            i_r   <= i_r + AW'(1);
            st_r  <= last_q ? ST_FIN : ST_QRD;
          end else begin
            sq_in_r    <= {best_r, {(2 * FRAC_W){1'b0}}};
            sq_start_r <= 1'b1;
            st_r       <= ST_PSQ;
          end
        end
        ST_PSQ: begin
          if (sq_done) begin
            if (mode_r == MODE_CHAMFER)       acc_r <= acc_r + ACC_W'(root);
            else if (ACC_W'(root) > acc_r)    acc_r <= ACC_W'(root);
            i_r  <= i_r + AW'(1);
            st_r <= last_q ? ST_FIN : ST_QRD;
          end
        end
        ST_FIN: begin
          if (mode_r == MODE_HAUSDORFF) begin
            dist_r <= acc_r[DIST_W-1:0];
            st_r   <= ST_DIR;
          end else begin
            dv_in_r    <= (mode_r == MODE_CHAMFER) ? DVD_W'(acc_r)
                                                   : {acc_r, {(2 * FRAC_W){1'b0}}};
            dv_start_r <= 1'b1;
            st_r       <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dv_done) begin
            if (mode_r == MODE_CHAMFER) begin
              dist_r <= quot[DIST_W-1:0];
              st_r   <= ST_DIR;
            end else begin
              // mean of squares at 16 fraction bits stays below 2^50
              sq_in_r    <= quot[SQ_IN_W-1:0];
              sq_start_r <= 1'b1;
              st_r       <= ST_RSQ;
            end
          end
        end
        ST_RSQ: begin
          if (sq_done) begin
            dist_r <= DIST_W'(root);
            st_r   <= ST_DIR;
          end
        end
        ST_DIR: begin
          if (!dir_r) begin
            da_r  <= dist_r;
            dir_r <= 1'b1;
            i_r   <= '0;
            acc_r <= '0;
            st_r  <= ST_QRD;
          end else begin
            db_r <= dist_r;
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_da_r    <= da_r;
            out_db_r    <= db_r;
            out_comb_r  <= (mode_r == MODE_HAUSDORFF) ? ((da_r > db_r) ? da_r : db_r)
                                                      : half_sum[DIST_W-1:0];
            out_stat_r  <= stat_r;
            out_valid_r <= 1'b1;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  psde_div #(
    .DVD_W (DVD_W),
    .DVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start_r),
    .dividend (dv_in_r),
    .divisor  (nq),
    .done     (dv_done),
    .quot     (quot)
  );

  psde_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start_r),
    .radicand (sq_in_r),
    .done     (sq_done),
    .root     (root)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_comb_r, out_db_r, out_da_r};
  assign out_tuser  = out_stat_r;

  // counts never pass capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CW'(MAX_POINTS)) && (count_b_r <= CW'(MAX_POINTS)))
    else $error("point count beyond capacity");

  // stores are written only while the sequencer is idle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (we_a || we_b) |-> (st_r == ST_IDLE))
    else $error("store written during a scan");

  // a new result is only launched from the result state
  a_out_launch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_OUT))
    else $error("result raised outside the result state");

  // an empty-set result carries zero distances
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == STATUS_EMPTY) |->
      (out_da_r == '0 && out_db_r == '0 && out_comb_r == '0))
    else $error("empty-set result with nonzero distance");

endmodule
